// ===== design/hrkm_pkg.sv =====
// Shared types, constants and the HID code to key matrix lookup for the
// HID report to key matrix block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrkm_pkg;

   localparam int REPORT_KEYS  = 6;
   localparam int REPORT_SLOTS = 6;
   localparam int MATRIX_ROWS  = 8;
   localparam int ROW_BITS     = 5;
   localparam int ROW_IDX_W    = $clog2(MATRIX_ROWS);

   localparam logic [ROW_BITS-1:0] ROW_MASK = '1;

   localparam logic [7:0] FIRST_MAPPED      = 8'h04;
   localparam logic [7:0] LAST_MAPPED       = 8'h2C;
   localparam logic [7:0] CAPS_SHIFT_CODE   = 8'h39;
   localparam logic [7:0] SYMBOL_SHIFT_CODE = 8'hE8;

   localparam logic [2:0] CAPS_ROW = 3'd0;
   localparam logic [2:0] CAPS_COL = 3'd0;
   localparam logic [2:0] SYM_ROW  = 3'd7;
   localparam logic [2:0] SYM_COL  = 3'd1;

   localparam int LSHIFT_BIT = 1;
   localparam int RSHIFT_BIT = 5;

   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // bit 6 set: unmapped; else row in [5:3], column in [2:0]
   localparam logic [6:0] NO_KEY = 7'h40;
   localparam int MAP_DEPTH = 41;
   localparam logic [6:0] KEY_MAP [0:MAP_DEPTH-1] = '{
      7'h08, 7'h3C, 7'h03, 7'h0A, 7'h12, 7'h0B, 7'h0C, 7'h34,
      7'h2A, 7'h33, 7'h32, 7'h31, 7'h3A, 7'h3B, 7'h29, 7'h28,
      7'h10, 7'h13, 7'h09, 7'h14, 7'h2B, 7'h04, 7'h11, 7'h02,
      7'h2C, 7'h01,
      7'h18, 7'h19, 7'h1A, 7'h1B, 7'h1C,
      7'h24, 7'h23, 7'h22, 7'h21, 7'h20,
      7'h30, NO_KEY, NO_KEY, NO_KEY, 7'h38
   };

   typedef logic [MATRIX_ROWS-1:0][ROW_BITS-1:0] hrkm_matrix_type;
   typedef logic [REPORT_KEYS-1:0][7:0]          hrkm_codes_type;

   typedef struct packed {
      logic                         cmd;
      logic [7:0]                   modifiers;
      logic [REPORT_SLOTS-1:0][7:0] key_codes;
      logic [7:0]                   row_select;
   } hrkm_item_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] row;
      logic [2:0] col;
   } hrkm_entry_type;

   function automatic hrkm_entry_type key_entry(input logic [7:0] code);
      hrkm_entry_type e;
      logic [7:0]     idx;
      logic [6:0]     m;
      e   = '0;
      idx = code - FIRST_MAPPED;
      m   = KEY_MAP[idx[5:0]];
      if (code >= FIRST_MAPPED && code <= LAST_MAPPED) begin
         e.hit = ~m[6];
         e.row = m[5:3];
         e.col = m[2:0];
      end else if (code == CAPS_SHIFT_CODE) begin
         e.hit = 1'b1;
         e.row = CAPS_ROW;
         e.col = CAPS_COL;
      end else if (code == SYMBOL_SHIFT_CODE) begin
         e.hit = 1'b1;
         e.row = SYM_ROW;
         e.col = SYM_COL;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== design/hid_report_to_key_matrix.sv =====
// Top level: HID boot report to key matrix, with input register, matrix
// state and result register. Uses hrkm_pkg, hrkm_key_update, hrkm_matrix_read.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------
//   req      | req_valid / req_stall   | cmd, modifiers, key_code_0..5, row_select
//   rsp      | rsp_valid / rsp_stall   | column_bits
//
// One transaction per cycle while rsp is not stalled; each passes the input
// register and is then loaded into the result register once that is free.
// The report update and the read logic sit between the two registers.
// Reset clears the matrix to all ones (no key pressed) and previous codes to 0.
// A stalled result holds; one more transaction is still taken into the input
// register, after which req_stall follows rsp_stall.
`timescale 1ns / 1ps
`default_nettype none

module hid_report_to_key_matrix (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_modifiers,
   input  logic [7:0]  req_key_code_0,
   input  logic [7:0]  req_key_code_1,
   input  logic [7:0]  req_key_code_2,
   input  logic [7:0]  req_key_code_3,
   input  logic [7:0]  req_key_code_4,
   input  logic [7:0]  req_key_code_5,
   input  logic [7:0]  req_row_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_column_bits
);

   logic                                s1_valid_ff, s1_valid_in;
   hrkm_pkg::hrkm_item_type             s1_item_ff, s1_item_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [hrkm_pkg::ROW_BITS-1:0]       column_ff, column_in;
   hrkm_pkg::hrkm_matrix_type           matrix_ff, matrix_in;
   hrkm_pkg::hrkm_codes_type            prev_ff, prev_in;

   hrkm_pkg::hrkm_codes_type            cur_codes;
   hrkm_pkg::hrkm_matrix_type           matrix_next;
   logic [hrkm_pkg::ROW_BITS-1:0]       read_bits;
   logic                                out_free;
   logic                                s1_go;
   logic                                req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      for (int i = 0; i < hrkm_pkg::REPORT_KEYS; i++) begin
         cur_codes[i] = s1_item_ff.key_codes[i];
      end
   end

   hrkm_key_update u_update (
      .matrix      (matrix_ff),
      .prev_codes  (prev_ff),
      .cur_codes   (cur_codes),
      .modifiers   (s1_item_ff.modifiers),
      .matrix_next (matrix_next)
   );

   hrkm_matrix_read u_read (
      .matrix      (matrix_ff),
      .row_select  (s1_item_ff.row_select),
      .column_bits (read_bits)
   );

   always_comb begin
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      s1_item_in   = s1_item_ff;
      if (req_take) begin
         s1_item_in.cmd        = req_cmd;
         s1_item_in.modifiers  = req_modifiers;
         s1_item_in.key_codes  = {req_key_code_5, req_key_code_4, req_key_code_3,
                                  req_key_code_2, req_key_code_1, req_key_code_0};
         s1_item_in.row_select = req_row_select;
      end
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      column_in    = column_ff;
      matrix_in    = matrix_ff;
      prev_in      = prev_ff;
      if (s1_go) begin
         unique case (s1_item_ff.cmd)
            hrkm_pkg::CMD_READ: begin
               column_in = read_bits;
            end
            hrkm_pkg::CMD_REPORT: begin
               column_in = hrkm_pkg::ROW_MASK;
               matrix_in = matrix_next;
               prev_in   = cur_codes;
            end
            default: begin
               column_in = hrkm_pkg::ROW_MASK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         matrix_ff    <= '1;
         prev_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         matrix_ff    <= matrix_in;
         prev_ff      <= prev_in;
      end
      s1_item_ff <= s1_item_in;
      column_ff  <= column_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_bits = column_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("req_stall without a held result");

   a_report_ones: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_item_ff.cmd == hrkm_pkg::CMD_REPORT |=> column_ff == hrkm_pkg::ROW_MASK)
      else $error("report result is not all ones");

   a_prev_saved: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_item_ff.cmd == hrkm_pkg::CMD_REPORT |=> prev_ff == $past(cur_codes))
      else $error("previous codes not updated");

   a_read_keeps: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_item_ff.cmd == hrkm_pkg::CMD_READ |=> $stable(matrix_ff) && $stable(prev_ff))
      else $error("read changed state");

   a_no_rows: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_item_ff.cmd == hrkm_pkg::CMD_READ && s1_item_ff.row_select == 8'hFF
      |=> column_ff == hrkm_pkg::ROW_MASK)
      else $error("read with no row selected is not all ones");

endmodule

`default_nettype wire

// ===== design/hrkm_key_update.sv =====
// Next key matrix for one keyboard report: shift handling, then presses of
// new codes and releases of vanished codes. Uses hrkm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrkm_key_update (
   input  hrkm_pkg::hrkm_matrix_type matrix,
   input  hrkm_pkg::hrkm_codes_type  prev_codes,
   input  hrkm_pkg::hrkm_codes_type  cur_codes,
   input  logic [7:0]                modifiers,
   output hrkm_pkg::hrkm_matrix_type matrix_next
);

   logic                          cur_new   [hrkm_pkg::REPORT_KEYS];
   logic                          prev_gone [hrkm_pkg::REPORT_KEYS];
   hrkm_pkg::hrkm_entry_type      cur_ent   [hrkm_pkg::REPORT_KEYS];
   hrkm_pkg::hrkm_entry_type      prev_ent  [hrkm_pkg::REPORT_KEYS];
   hrkm_pkg::hrkm_matrix_type     press;
   hrkm_pkg::hrkm_matrix_type     release_mask;
   logic                          shift;

   assign shift = modifiers[hrkm_pkg::LSHIFT_BIT] | modifiers[hrkm_pkg::RSHIFT_BIT];

   always_comb begin
      for (int i = 0; i < hrkm_pkg::REPORT_KEYS; i++) begin
         cur_new[i]   = 1'b1;
         prev_gone[i] = 1'b1;
         for (int k = 0; k < hrkm_pkg::REPORT_KEYS; k++) begin
            if (prev_codes[k] == cur_codes[i]) cur_new[i] = 1'b0;
            if (cur_codes[k] == prev_codes[i]) prev_gone[i] = 1'b0;
         end
         cur_ent[i]  = hrkm_pkg::key_entry(cur_codes[i]);
         prev_ent[i] = hrkm_pkg::key_entry(prev_codes[i]);
      end
   end

   // Distinct codes map to distinct bits, so a press and a release never
   // meet on one bit; both override the shift modifier.
   always_comb begin
      press        = '0;
      release_mask = '0;
      for (int r = 0; r < hrkm_pkg::MATRIX_ROWS; r++) begin
         for (int c = 0; c < hrkm_pkg::ROW_BITS; c++) begin
            for (int i = 0; i < hrkm_pkg::REPORT_KEYS; i++) begin
               if (cur_new[i] && cur_ent[i].hit &&
                   cur_ent[i].row == 3'(r) && cur_ent[i].col == 3'(c)) begin
                  press[r][c] = 1'b1;
               end
               if (prev_gone[i] && prev_ent[i].hit &&
                   prev_ent[i].row == 3'(r) && prev_ent[i].col == 3'(c)) begin
                  release_mask[r][c] = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      matrix_next = matrix;
      matrix_next[hrkm_pkg::SYM_ROW][hrkm_pkg::SYM_COL] = ~shift;
      matrix_next = (matrix_next & ~press) | release_mask;
   end

endmodule

`default_nettype wire

// ===== design/hrkm_matrix_read.sv =====
// Matrix read: AND of the rows whose select bit is low.
// Uses hrkm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrkm_matrix_read (
   input  hrkm_pkg::hrkm_matrix_type                  matrix,
   input  logic [hrkm_pkg::MATRIX_ROWS-1:0]           row_select,
   output logic [hrkm_pkg::ROW_BITS-1:0]              column_bits
);

   always_comb begin
      column_bits = hrkm_pkg::ROW_MASK;
      for (int r = 0; r < hrkm_pkg::MATRIX_ROWS; r++) begin
         if (!row_select[r]) column_bits = column_bits & matrix[r];
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_hid_report_to_key_matrix.sv =====
// Self-checking testbench for hid_report_to_key_matrix: directed table, then random
// reports and matrix reads under random idling, checked against a matrix tracker.
// Depends on hrkm_pkg and the hid_report_to_key_matrix RTL.
`timescale 1ns / 1ps

module tb_hid_report_to_key_matrix;

   typedef struct packed {
      logic            cmd;
      logic [7:0]      mods;
      logic [5:0][7:0] codes;   // slot 0 in the low byte
      logic [7:0]      sel;
   } key_txn_type;

   typedef struct packed {
      key_txn_type txn;
      logic        pinned;       // expected column bits typed in below
      logic [4:0]  col;
   } stim_row_type;

   localparam logic [7:0] UNMAPPED   = 8'hFF;
   localparam logic [7:0] SYM_SHIFT  = 8'h39;   // row 7, column 1
   localparam logic [7:0] CAPS_SHIFT = 8'h00;   // row 0, column 0

   localparam logic RD = hrkm_pkg::CMD_READ;
   localparam logic RP = hrkm_pkg::CMD_REPORT;

   // HID codes 0x04..0x2C; entry = row * 8 + column
   localparam logic [7:0] KEY_POS [41] = '{
      8'h08, 8'h3C, 8'h03, 8'h0A, 8'h12, 8'h0B, 8'h0C, 8'h34,
      8'h2A, 8'h33, 8'h32, 8'h31, 8'h3A, 8'h3B, 8'h29, 8'h28,
      8'h10, 8'h13, 8'h09, 8'h14, 8'h2B, 8'h04, 8'h11, 8'h02,
      8'h2C, 8'h01,
      8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C,
      8'h24, 8'h23, 8'h22, 8'h21, 8'h20,
      8'h30, UNMAPPED, UNMAPPED, UNMAPPED, 8'h38
   };

   localparam int DIR_ROWS = 25;
   localparam stim_row_type DIRECTED [DIR_ROWS] = '{
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'hFF}, 1'b1, 5'h1F},
      '{'{RP, 8'h02, 48'h00_00_00_00_00_00, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'h7F}, 1'b1, 5'h1D},
      '{'{RP, 8'h20, 48'h00_00_00_00_00_04, 8'hFF}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'hFD}, 1'b1, 5'h1E},
      '{'{RP, 8'h00, 48'h00_00_00_00_39_04, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'hFE}, 1'b1, 5'h1E},
      // symbol shift code and unmapped codes, shift bits clear
      '{'{RP, 8'hDD, 48'h2D_00_2C_FF_05_E8, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'h7F}, 1'b0, 5'h00},
      // duplicates within one report
      '{'{RP, 8'h22, 48'h00_00_1F_1E_1E_1E, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'hF7}, 1'b0, 5'h00},
      // release of one key leaves its row neighbor pressed
      '{'{RP, 8'h00, 48'h00_00_1F_00_00_00, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'hF7}, 1'b0, 5'h00},
      '{'{RP, 8'hFF, 48'hFF_FF_FF_FF_FF_FF, 8'hFF}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'h00}, 1'b0, 5'h00},
      // code 0xE8 pressed overrides the shift release
      '{'{RP, 8'h00, 48'hE8_00_00_00_00_00, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'h7F}, 1'b0, 5'h00},
      // code 0xE8 leaving overrides the shift press
      '{'{RP, 8'h02, 48'h00_00_00_00_00_00, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'h7F}, 1'b0, 5'h00},
      '{'{RP, 8'h00, 48'h2C_25_16_1D_28_27, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'h00}, 1'b0, 5'h00},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'hAA}, 1'b0, 5'h00},
      '{'{RP, 8'h00, 48'h00_00_00_00_00_00, 8'h00}, 1'b1, 5'h1F},
      '{'{RD, 8'h00, 48'h00_00_00_00_00_00, 8'h00}, 1'b0, 5'h00}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_cmd = 1'b0;
   logic [7:0] req_modifiers = '0;
   logic [7:0] req_key_code_0 = '0;
   logic [7:0] req_key_code_1 = '0;
   logic [7:0] req_key_code_2 = '0;
   logic [7:0] req_key_code_3 = '0;
   logic [7:0] req_key_code_4 = '0;
   logic [7:0] req_key_code_5 = '0;
   logic [7:0] req_row_select = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [4:0] rsp_column_bits;

   // typed expectation travels with the payload
   logic       row_pinned = 1'b0;
   logic [4:0] row_pinned_col = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;

   logic [7:0][4:0] key_matrix;
   logic [5:0][7:0] last_codes;
   logic [4:0]      expected_columns [$];

   hid_report_to_key_matrix dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_modifiers   (req_modifiers),
      .req_key_code_0  (req_key_code_0),
      .req_key_code_1  (req_key_code_1),
      .req_key_code_2  (req_key_code_2),
      .req_key_code_3  (req_key_code_3),
      .req_key_code_4  (req_key_code_4),
      .req_key_code_5  (req_key_code_5),
      .req_row_select  (req_row_select),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column_bits (rsp_column_bits)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] key_pos_of(input logic [7:0] code);
      if (code >= 8'h04 && code <= 8'h2C) return KEY_POS[code - 8'h04];
      if (code == 8'h39) return CAPS_SHIFT;
      if (code == 8'hE8) return SYM_SHIFT;
      return UNMAPPED;
   endfunction

   function automatic void set_key(input logic [7:0] pos, input logic down);
      if (pos == UNMAPPED) return;
      key_matrix[pos[5:3]][pos[2:0]] = ~down;
   endfunction

   function automatic logic code_listed(input logic [5:0][7:0] list, input logic [7:0] code);
      for (int k = 0; k < hrkm_pkg::REPORT_KEYS; k++)
         if (list[k] == code) return 1'b1;
      return 1'b0;
   endfunction

   // Updates the tracked matrix for a report and returns all ones; returns the column bits a read gives.
   function automatic logic [4:0] spectrum_columns(input key_txn_type t);
      logic [4:0]      acc;
      logic [5:0][7:0] cur;
      acc = '1;
      cur = '0;
      if (t.cmd == hrkm_pkg::CMD_READ) begin
         for (int r = 0; r < hrkm_pkg::MATRIX_ROWS; r++)
            if (!t.sel[r]) acc &= key_matrix[r];
         return acc;
      end
      for (int i = 0; i < hrkm_pkg::REPORT_KEYS; i++) cur[i] = t.codes[i];
      set_key(SYM_SHIFT, t.mods[hrkm_pkg::LSHIFT_BIT] | t.mods[hrkm_pkg::RSHIFT_BIT]);
      for (int i = 0; i < hrkm_pkg::REPORT_KEYS; i++) begin
         if (!code_listed(last_codes, cur[i])) set_key(key_pos_of(cur[i]), 1'b1);
         if (!code_listed(cur, last_codes[i])) set_key(key_pos_of(last_codes[i]), 1'b0);
      end
      last_codes = cur;
      return acc;
   endfunction

   always @(posedge clock) begin : track
      key_txn_type seen;
      logic [4:0]  want;
      logic [4:0]  got_exp;
      if (reset) begin
         key_matrix = {hrkm_pkg::MATRIX_ROWS{5'h1F}};
         last_codes = '0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            seen.cmd   = req_cmd;
            seen.mods  = req_modifiers;
            seen.codes = {req_key_code_5, req_key_code_4, req_key_code_3,
                          req_key_code_2, req_key_code_1, req_key_code_0};
            seen.sel   = req_row_select;
            want = spectrum_columns(seen);
            if (row_pinned) want = row_pinned_col;
            expected_columns.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_columns.size() == 0) begin
               $error("column_bits: expected none, actual %0h", rsp_column_bits);
               fail_count++;
            end else begin
               got_exp = expected_columns.pop_front();
               if (rsp_column_bits !== got_exp) begin
                  $error("column_bits: expected %0h, actual %0h", got_exp, rsp_column_bits);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Call at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_txn(input key_txn_type t, input logic pin, input logic [4:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_cmd        <= t.cmd;
      req_modifiers  <= t.mods;
      req_key_code_0 <= t.codes[0];
      req_key_code_1 <= t.codes[1];
      req_key_code_2 <= t.codes[2];
      req_key_code_3 <= t.codes[3];
      req_key_code_4 <= t.codes[4];
      req_key_code_5 <= t.codes[5];
      req_row_select <= t.sel;
      row_pinned     <= pin;
      row_pinned_col <= col;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   initial begin : stimulus
      logic [5:0][7:0] held_codes;
      held_codes = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 29;
      recv_stall_pct = 63;
      foreach (DIRECTED[n]) send_txn(DIRECTED[n].txn, DIRECTED[n].pinned, DIRECTED[n].col);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 29 : (phase == 1) ? 63 : 0;
         recv_stall_pct = (phase == 0) ? 63 : (phase == 1) ? 29 : 0;
         repeat (530) begin : gen
            key_txn_type t;
            int          r;
            t = '0;
            if ($urandom_range(99) < 45) begin
               t.cmd = hrkm_pkg::CMD_READ;
               r = $urandom_range(99);
               if (r < 45)      t.sel = ~(8'h01 << $urandom_range(7));
               else if (r < 55) t.sel = 8'hFF;
               else if (r < 62) t.sel = 8'h00;
               else             t.sel = 8'($urandom_range(255));
               t.mods  = 8'($urandom_range(255));
               t.codes = {$urandom, 16'($urandom)};
            end else begin
               t.cmd = hrkm_pkg::CMD_REPORT;
               if ($urandom_range(99) < 70) begin
                  case ($urandom_range(3))
                     0: t.mods = 8'h00;
                     1: t.mods = 8'h02;
                     2: t.mods = 8'h20;
                     default: t.mods = 8'h22;
                  endcase
               end else begin
                  t.mods = 8'($urandom_range(255));
               end
               // rollover: each key slot stays held across reports 40 percent of the time
               for (int i = 0; i < 6; i++) begin
                  r = $urandom_range(99);
                  if (r < 40)      t.codes[i] = held_codes[i];
                  else if (r < 52) t.codes[i] = 8'h00;
                  else if (r < 80) t.codes[i] = 8'($urandom_range(8'h2C, 8'h04));
                  else if (r < 85) t.codes[i] = 8'h39;
                  else if (r < 90) t.codes[i] = 8'hE8;
                  else             t.codes[i] = 8'($urandom_range(255));
               end
               t.sel = 8'($urandom_range(255));
               held_codes = t.codes;
            end
            send_txn(t, 1'b0, 5'h00);
         end
      end

      req_valid <= 1'b0;
      while (expected_columns.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_hid_report_to_key_matrix: PASS");
      end else begin
         $display("tb_hid_report_to_key_matrix: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb_hid_report_to_key_matrix: FAIL");
      $finish;
   end

endmodule
